// ----- rtl/wfn_pkg.sv -----
// wfn_pkg: shared constants and types for the first-negative window stream block
// used by wfn_front, wfn_back and window_first_negative_stream_core
package wfn_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // window size register, fixed width
    localparam int         WS_W     = 7;
    localparam logic [6:0] WS_RESET = 7'd1;

    // classification of one sample, carried from front to back
    typedef struct packed {
        logic neg;
        logic last;
    } item_ctl_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic fire;
        logic has_result;
    } back_status_t;

endpackage

// ----- rtl/window_first_negative_stream_core.sv -----
// window_first_negative_stream_core: top level, depends on wfn_pkg, wfn_front and wfn_back
// a sample is held in the front queue, then its result is registered in the back end
// throughput: while result_stall is low, one sample and one back-end queue step per cycle
// with the head and next entry prefetched; input stalls only while two transactions wait
// reset clears the queue, fill count and position; window_size resets to 1
// no clearing pass: memory entries are only read after being written
module window_first_negative_stream_core #(
    parameter int WINDOW_MAX   = wfn_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = wfn_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     window_size_we,
    input  logic [wfn_pkg::WS_W-1:0] window_size,
    input  logic [SAMPLE_WIDTH-1:0]  sample,
    input  logic                     last_sample,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    output logic [SAMPLE_WIDTH-1:0]  first_negative,
    output logic                     result_valid,
    input  logic                     result_stall
);

    logic [wfn_pkg::WS_W-1:0] window_size_reg;
    logic [wfn_pkg::WS_W-1:0] window_size_next;
    logic [SAMPLE_WIDTH-1:0]  q_sample;
    wfn_pkg::item_ctl_t       q_ctl;
    logic                     q_valid;
    logic                     q_take;
    wfn_pkg::back_status_t    stat;

    assign window_size_next = window_size_we ? window_size : window_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= wfn_pkg::WS_RESET;
        else
            window_size_reg <= window_size_next;
    end

    wfn_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .last_sample  (last_sample),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .q_sample     (q_sample),
        .q_ctl        (q_ctl),
        .q_valid      (q_valid),
        .q_take       (q_take)
    );

    wfn_back #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size    (window_size_reg),
        .q_sample       (q_sample),
        .q_ctl          (q_ctl),
        .q_valid        (q_valid),
        .q_take         (q_take),
        .first_negative (first_negative),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .stat           (stat)
    );

    // a result is never positive
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (first_negative[SAMPLE_WIDTH-1] || (first_negative == '0)))
        else $error("positive result delivered");

    // a new result comes only from a step that produced one
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stat.fire && stat.has_result))
        else $error("result without a producing step");

    // an accepted transaction reaches the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && !q_valid) |=> q_valid)
        else $error("accepted transaction lost before the queue");

endmodule

// ----- rtl/wfn_front.sv -----
// wfn_front: accepts samples, classifies them and holds them in a two-entry queue
// depends on wfn_pkg (item_ctl_t)
module wfn_front #(
    parameter int SAMPLE_WIDTH = wfn_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    last_sample,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    output logic [SAMPLE_WIDTH-1:0] q_sample,
    output wfn_pkg::item_ctl_t      q_ctl,
    output logic                    q_valid,
    input  logic                    q_take
);

    logic [SAMPLE_WIDTH-1:0] smp_reg [2];
    wfn_pkg::item_ctl_t      ctl_reg [2];
    logic                    wr_ptr_reg;
    logic                    wr_ptr_next;
    logic                    rd_ptr_reg;
    logic                    rd_ptr_next;
    logic [1:0]              cnt_reg;
    logic [1:0]              cnt_next;
    logic                    push;
    logic                    pop;
    wfn_pkg::item_ctl_t      ctl_in;

    assign sample_stall = (cnt_reg == 2'd2);
    assign push         = sample_valid && !sample_stall;
    assign q_valid      = (cnt_reg != 2'd0);
    assign pop          = q_take && q_valid;
    assign q_sample     = smp_reg[rd_ptr_reg];
    assign q_ctl        = ctl_reg[rd_ptr_reg];

    always_comb
    begin
        ctl_in.neg  = sample[SAMPLE_WIDTH-1];
        ctl_in.last = last_sample;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            smp_reg[wr_ptr_reg] <= sample;
            ctl_reg[wr_ptr_reg] <= ctl_in;
        end
    end

endmodule

// ----- rtl/wfn_back.sv -----
// wfn_back: negative-sample ring queue, window bookkeeping and result register
// depends on wfn_pkg (item_ctl_t, back_status_t, WS_W)
module wfn_back #(
    parameter int WINDOW_MAX   = wfn_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = wfn_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [wfn_pkg::WS_W-1:0]  window_size,
    input  logic [SAMPLE_WIDTH-1:0]   q_sample,
    input  wfn_pkg::item_ctl_t        q_ctl,
    input  logic                      q_valid,
    output logic                      q_take,
    output logic [SAMPLE_WIDTH-1:0]   first_negative,
    output logic                      result_valid,
    input  logic                      result_stall,
    output wfn_pkg::back_status_t     stat
);

    localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int POS_W   = $clog2(2 * WINDOW_MAX);
    localparam int CMP_W   = (POS_W > wfn_pkg::WS_W) ? POS_W : wfn_pkg::WS_W;
    localparam int ENT_W   = SAMPLE_WIDTH + POS_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(WINDOW_MAX);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * WINDOW_MAX - 1);
    localparam logic [POS_W:0]   POS_MOD  = (POS_W + 1)'(2 * WINDOW_MAX);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // queue storage: {value, position}
    logic [ENT_W-1:0] mem [WINDOW_MAX];
    logic [ENT_W-1:0] rd0_reg;
    logic [ENT_W-1:0] rd1_reg;

    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    result_valid_reg, result_valid_next;
    logic [SAMPLE_WIDTH-1:0] first_negative_reg;

    logic                    fire;
    logic                    drop;
    logic                    pop;
    logic                    has_res;
    logic                    front_from_in;
    logic [IDX_W-1:0]        head_a;
    logic [CNT_W-1:0]        count_a;
    logic [CNT_W-1:0]        fill_a;
    logic [CMP_W-1:0]        ws_ext;
    logic [CNT_W-1:0]        ws_c;
    logic [ENT_W-1:0]        front;
    logic [SAMPLE_WIDTH-1:0] front_val;
    logic [POS_W-1:0]        front_pos;
    logic [POS_W:0]          age_w;
    logic [POS_W-1:0]        age;
    logic [SAMPLE_WIDTH-1:0] res_val;
    logic [ENT_W-1:0]        wdata;
    logic                    wr_en;
    logic [IDX_W-1:0]        rd_addr0;
    logic [IDX_W-1:0]        rd_addr1;

    assign fire           = q_valid && (!result_valid_reg || !result_stall);
    assign q_take         = fire;
    assign result_valid   = result_valid_reg;
    assign first_negative = first_negative_reg;
    assign stat.fire       = fire;
    assign stat.has_result = has_res;

    always_comb
    begin
        // window size zero acts as one, large sizes saturate
        ws_ext = CMP_W'(window_size);
        if (ws_ext == '0)
            ws_c = CNT_W'(1);
        else if (ws_ext > CMP_W'(WINDOW_MAX))
            ws_c = MAX_CNT;
        else
            ws_c = CNT_W'(ws_ext);

        drop    = q_ctl.neg && (count_reg == MAX_CNT);
        head_a  = drop ? ring_next(head_reg) : head_reg;
        count_a = count_reg - CNT_W'(drop) + CNT_W'(q_ctl.neg);
        fill_a  = (fill_reg < ws_c) ? fill_reg + 1'b1 : fill_reg;
        has_res = (fill_a >= ws_c);

        // front after the push: the new sample, the second prefetched entry, or the head
        front_from_in = (count_reg == '0) || (drop && (count_reg == CNT_W'(1)));
        if (front_from_in)
            front = {q_sample, pos_reg};
        else if (drop)
            front = rd1_reg;
        else
            front = rd0_reg;
        front_val = front[ENT_W-1:POS_W];
        front_pos = front[POS_W-1:0];

        age_w = {1'b0, pos_reg} - {1'b0, front_pos}
                + ((pos_reg < front_pos) ? POS_MOD : '0);
        age   = age_w[POS_W-1:0];

        res_val = (count_a != '0) ? front_val : '0;
        pop     = has_res && (count_a != '0)
                  && (CMP_W'(age) >= (CMP_W'(ws_c) - 1'b1));

        head_next  = pop ? ring_next(head_a) : head_a;
        count_next = count_a - CNT_W'(pop);
        tail_next  = q_ctl.neg ? ring_next(tail_reg) : tail_reg;
        fill_next  = fill_a;
        pos_next   = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        if (q_ctl.last)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            fill_next  = '0;
            pos_next   = '0;
        end

        if (fire)
            result_valid_next = has_res;
        else
            result_valid_next = result_valid_reg && result_stall;

        wr_en    = fire && q_ctl.neg;
        wdata    = {q_sample, pos_reg};
        rd_addr0 = fire ? head_next : head_reg;
        rd_addr1 = ring_next(rd_addr0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            fill_reg         <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                fill_reg  <= fill_next;
                pos_reg   <= pos_next;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_res)
            first_negative_reg <= res_val;
    end

    // prefetch head and head+1, forwarding a write to the same entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[tail_reg] <= wdata;
        rd0_reg <= (wr_en && (tail_reg == rd_addr0)) ? wdata : mem[rd_addr0];
        rd1_reg <= (wr_en && (tail_reg == rd_addr1)) ? wdata : mem[rd_addr1];
    end

endmodule
